@@ hdl/stepper_axis_homing_control_top_macros.svh @@
// ----------------------------------------------------------------------------
// Stepper axis homing control - assertion macros
// Shared concurrent assertion forms, clocked on rising edge, reset disabled.
// ----------------------------------------------------------------------------
`ifndef STEPPER_AXIS_HOMING_CONTROL_TOP_MACROS_SVH
`define STEPPER_AXIS_HOMING_CONTROL_TOP_MACROS_SVH

// same-cycle implication
`define SAHC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sahc assertion failed");

// next-cycle implication
`define SAHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sahc assertion failed");

`endif

@@ hdl/sahc_pkg.sv @@
// ----------------------------------------------------------------------------
// sahc_pkg
// Types and codes shared by the stepper axis homing control block.
// ----------------------------------------------------------------------------
package sahc_pkg;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_HOME  = 2'd1,
      KIND_MOVE  = 2'd2,
      KIND_STOP  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_HOMING = 2'd1,
      MODE_MOVE   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SAFETY = 2'd1,
      EV_HOME   = 2'd2,
      EV_TARGET = 2'd3
   } event_type;

   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOME_TOWARD    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAFETY_PRESENT = 1'b1;

   localparam int unsigned STEP_W = 31;
   localparam int unsigned POS_W  = 32;

   typedef struct packed {
      logic home_toward;
      logic safety_present;
   } cfg_type;

   typedef struct packed {
      kind_type           kind;
      logic [STEP_W-1:0]  step_count;
      logic               move_dir;
      logic               home_hit;
      logic               safety_hit;
      logic               step_done;
   } req_item_type;

   typedef struct packed {
      event_type                event_res;
      mode_type                 axis_mode;
      logic                     is_homed;
      logic signed [POS_W-1:0]  position;
      logic                     drive_enable;
      logic                     drive_dir;
      logic                     step_permit;
      logic                     count_clear;
   } rsp_item_type;

endpackage

@@ hdl/sahc_if.sv @@
// ----------------------------------------------------------------------------
// sahc_req_if / sahc_rsp_if
// Valid/ready item channels for requests and responses.
// ----------------------------------------------------------------------------
interface sahc_req_if import sahc_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface sahc_rsp_if import sahc_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/sahc_csr.sv @@
// ----------------------------------------------------------------------------
// sahc_csr
// Configuration registers, written by index.
// ----------------------------------------------------------------------------
module sahc_csr import sahc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HOME_TOWARD:    cfg_in.home_toward    = csr_wdata[0];
            CSR_SAFETY_PRESENT: cfg_in.safety_present = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/sahc_in_stage.sv @@
// ----------------------------------------------------------------------------
// sahc_in_stage
// Input register for request items.
// ----------------------------------------------------------------------------
module sahc_in_stage import sahc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   sahc_req_if.sink      req_if,
   output logic          item_valid,
   output req_item_type  item,
   input  logic          item_take
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         accept;

   assign req_if.ready = !valid_ff || item_take;
   assign accept       = req_if.valid && req_if.ready;
   assign valid_in     = accept || (valid_ff && !item_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_if.data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ hdl/sahc_core.sv @@
// ----------------------------------------------------------------------------
// sahc_core
// Axis state, per-item update and response register.
// ----------------------------------------------------------------------------
module sahc_core import sahc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          item_valid,
   input  req_item_type  item,
   output logic          item_take,
   sahc_rsp_if.source    rsp_if
);

   mode_type                mode_ff, mode_in;
   logic                    homed_ff, homed_in;
   logic [STEP_W-1:0]       steps_ff, steps_in;
   logic signed [POS_W-1:0] pos_ff, pos_in;
   logic                    enable_ff, enable_in;
   logic                    dir_ff, dir_in;
   logic                    out_valid_ff, out_valid_in;
   rsp_item_type            rsp_ff;
   event_type               ev;
   logic                    permit;
   logic                    clear;
   logic                    moving;
   logic                    toward;

   assign item_take    = item_valid && (!out_valid_ff || rsp_if.ready);
   assign out_valid_in = item_take || (out_valid_ff && !rsp_if.ready);
   assign moving       = (mode_ff == MODE_HOMING) || (mode_ff == MODE_MOVE);
   assign toward       = (dir_ff == cfg.home_toward);

   always_comb begin
      mode_in   = mode_ff;
      homed_in  = homed_ff;
      steps_in  = steps_ff;
      pos_in    = pos_ff;
      enable_in = enable_ff;
      dir_in    = dir_ff;
      ev        = EV_NONE;
      permit    = 1'b0;
      clear     = 1'b0;
      unique case (item.kind)
         KIND_HOME: begin
            mode_in   = MODE_HOMING;
            homed_in  = 1'b0;
            dir_in    = cfg.home_toward;
            enable_in = 1'b1;
         end
         KIND_MOVE: begin
            mode_in   = MODE_MOVE;
            steps_in  = item.step_count;
            dir_in    = item.move_dir;
            enable_in = 1'b1;
         end
         KIND_STOP: begin
            mode_in   = MODE_IDLE;
            enable_in = 1'b0;
         end
         KIND_TICK: begin
            priority if (cfg.safety_present && moving && item.safety_hit) begin
               mode_in   = MODE_IDLE;
               enable_in = 1'b0;
               ev        = EV_SAFETY;
            end else if ((mode_ff == MODE_HOMING && item.home_hit) ||
                         (mode_ff == MODE_MOVE && toward && item.home_hit)) begin
               mode_in   = MODE_IDLE;
               enable_in = 1'b0;
               homed_in  = 1'b1;
               pos_in    = '0;
               clear     = 1'b1;
               ev        = EV_HOME;
            end else if (mode_ff == MODE_HOMING) begin
               permit = 1'b1;
            end else if (mode_ff == MODE_MOVE && (|steps_ff)) begin
               permit = 1'b1;
               if (item.step_done) begin
                  steps_in = steps_ff - STEP_W'(1);
                  pos_in   = toward ? pos_ff - POS_W'(1) : pos_ff + POS_W'(1);
               end
            end else if (mode_ff == MODE_MOVE) begin
               mode_in   = MODE_IDLE;
               enable_in = 1'b0;
               ev        = EV_TARGET;
            end else begin
               mode_in = mode_ff;
            end
         end
         default: mode_in = mode_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         homed_ff     <= 1'b0;
         steps_ff     <= '0;
         pos_ff       <= '0;
         enable_ff    <= 1'b0;
         dir_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (item_take) begin
            mode_ff   <= mode_in;
            homed_ff  <= homed_in;
            steps_ff  <= steps_in;
            pos_ff    <= pos_in;
            enable_ff <= enable_in;
            dir_ff    <= dir_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_ff.event_res    <= ev;
         rsp_ff.axis_mode    <= mode_in;
         rsp_ff.is_homed     <= homed_in;
         rsp_ff.position     <= pos_in;
         rsp_ff.drive_enable <= enable_in;
         rsp_ff.drive_dir    <= dir_in;
         rsp_ff.step_permit  <= permit;
         rsp_ff.count_clear  <= clear;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.data  = rsp_ff;

endmodule

@@ hdl/stepper_axis_homing_control_top.sv @@
// An accepted item passes the input register, then the result register, to its response.
// Throughput: one item per cycle unless responses stall; the mode, step and position
// registers update as an item is taken, so back-to-back items see the prior item's state.
// Reset (synchronous): axis idle, not homed, position and step count zero.
// ----------------------------------------------------------------------------
// stepper_axis_homing_control_top
// One stepper axis: homing, counted moves, safety stop, position tracking.
// ----------------------------------------------------------------------------
`include "stepper_axis_homing_control_top_macros.svh"

module stepper_axis_homing_control_top import sahc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   sahc_req_if.sink              req_if,
   sahc_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg;
   logic         item_valid;
   req_item_type item;
   logic         item_take;

   sahc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sahc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   sahc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_if     (rsp_if)
   );

   `SAHC_ASSERT_NEXT(a_accept_loads, clock, reset, req_if.valid && req_if.ready, item_valid)
   `SAHC_ASSERT_NEXT(a_take_shows, clock, reset, item_take, rsp_if.valid)
   `SAHC_ASSERT_IMPLY(a_home_found, clock, reset, rsp_if.valid && rsp_if.data.count_clear, rsp_if.data.event_res == EV_HOME && rsp_if.data.position == '0 && rsp_if.data.is_homed && !rsp_if.data.drive_enable)
   `SAHC_ASSERT_IMPLY(a_permit_driven, clock, reset, rsp_if.valid && rsp_if.data.step_permit, rsp_if.data.drive_enable && rsp_if.data.axis_mode != MODE_IDLE)

endmodule
